// File: src/jpd_pkg.sv
`default_nettype none
package jpd_pkg;

   localparam int NUM_BUTTON_SLOTS = 32;
   localparam int CODE_BITS = 8;
   localparam int CODE_WORD_BITS = 64;
   localparam int CODE_WORDS = 4;
   localparam int SLOT_CODE_BITS = CODE_WORDS * CODE_WORD_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam int STEP_BITS = 10;
   localparam int COUNT_BITS = 32;
   localparam int AXIS_BITS = 7;

   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 120;
   localparam int RSP_USED_BITS =
      STEP_BITS + 2 * COUNT_BITS + AXIS_BITS + NUM_BUTTON_SLOTS;

   localparam logic [CSR_ADDR_BITS-1:0] REG_STEP_BUTTON = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CODES_WORD0 = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CODES_WORD1 = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CODES_WORD2 = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CODES_WORD3 = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SLOT_ENABLE = 3'd5;

   localparam logic [CODE_BITS-1:0] AXIS_IDLE = 8'h00;
   localparam logic [CODE_BITS-1:0] AXIS_X    = 8'h11;
   localparam logic [CODE_BITS-1:0] AXIS_Y    = 8'h12;
   localparam logic [CODE_BITS-1:0] AXIS_Z    = 8'h13;
   localparam logic [CODE_BITS-1:0] AXIS_A    = 8'h18;
   localparam logic [CODE_BITS-1:0] AXIS_SPIN = 8'h14;
   localparam logic [CODE_BITS-1:0] AXIS_RATE = 8'h15;

   localparam logic [STEP_BITS-1:0] STEP_1    = 10'd1;
   localparam logic [STEP_BITS-1:0] STEP_10   = 10'd10;
   localparam logic [STEP_BITS-1:0] STEP_100  = 10'd100;
   localparam logic [STEP_BITS-1:0] STEP_1000 = 10'd1000;

   typedef struct packed {
      logic [CODE_BITS-1:0]        step_key_code;
      logic [SLOT_CODE_BITS-1:0]   slot_codes;
      logic [NUM_BUTTON_SLOTS-1:0] slot_enable;
   } cfg_type;

   typedef struct packed {
      logic signed [CODE_BITS-1:0] wheel_delta;
      logic [CODE_BITS-1:0]        axis_code;
      logic [CODE_BITS-1:0]        key_code;
   } item_type;

   typedef struct packed {
      logic [1:0]                  step_index;
      logic [COUNT_BITS-1:0]       jog_total;
   } state_type;

   typedef struct packed {
      logic [NUM_BUTTON_SLOTS-1:0] buttons_pressed;
      logic [AXIS_BITS-1:0]        axis_enables;
      logic signed [COUNT_BITS-1:0] jog_count_negated;
      logic signed [COUNT_BITS-1:0] jog_count;
      logic [STEP_BITS-1:0]        step_size;
   } result_type;

   function automatic logic [STEP_BITS-1:0] step_lookup(input logic [1:0] idx);
      logic [STEP_BITS-1:0] size;
      case (idx)
         2'd0:    size = STEP_1;
         2'd1:    size = STEP_10;
         2'd2:    size = STEP_100;
         default: size = STEP_1000;
      endcase
      return size;
   endfunction

   function automatic logic [AXIS_BITS-1:0] axis_lookup(input logic [CODE_BITS-1:0] code);
      logic [AXIS_BITS-1:0] onehot;
      case (code)
         AXIS_IDLE: onehot = 7'b000_0001;
         AXIS_X:    onehot = 7'b000_0010;
         AXIS_Y:    onehot = 7'b000_0100;
         AXIS_Z:    onehot = 7'b000_1000;
         AXIS_A:    onehot = 7'b001_0000;
         AXIS_RATE: onehot = 7'b010_0000;
         AXIS_SPIN: onehot = 7'b100_0000;
         default:   onehot = '0;
      endcase
      return onehot;
   endfunction

endpackage
`default_nettype wire

// File: src/jpd_csr.sv
`default_nettype none
module jpd_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [jpd_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [jpd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output jpd_pkg::cfg_type                        cfg
);

   jpd_pkg::cfg_type cfg_ff;
   jpd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            jpd_pkg::REG_STEP_BUTTON:
               cfg_in.step_key_code = csr_wdata[jpd_pkg::CODE_BITS-1:0];
            jpd_pkg::REG_CODES_WORD0:
               cfg_in.slot_codes[0*jpd_pkg::CODE_WORD_BITS +: jpd_pkg::CODE_WORD_BITS] =
                  csr_wdata;
            jpd_pkg::REG_CODES_WORD1:
               cfg_in.slot_codes[1*jpd_pkg::CODE_WORD_BITS +: jpd_pkg::CODE_WORD_BITS] =
                  csr_wdata;
            jpd_pkg::REG_CODES_WORD2:
               cfg_in.slot_codes[2*jpd_pkg::CODE_WORD_BITS +: jpd_pkg::CODE_WORD_BITS] =
                  csr_wdata;
            jpd_pkg::REG_CODES_WORD3:
               cfg_in.slot_codes[3*jpd_pkg::CODE_WORD_BITS +: jpd_pkg::CODE_WORD_BITS] =
                  csr_wdata;
            jpd_pkg::REG_SLOT_ENABLE:
               cfg_in.slot_enable = csr_wdata[jpd_pkg::NUM_BUTTON_SLOTS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: src/jpd_decode.sv
`default_nettype none
module jpd_decode (
   input  wire jpd_pkg::cfg_type    cfg,
   input  wire jpd_pkg::item_type   item,
   input  wire jpd_pkg::state_type  state,
   output jpd_pkg::state_type       state_next,
   output jpd_pkg::result_type      result
);

   logic                                   step_hit;
   logic [jpd_pkg::COUNT_BITS-1:0]         delta_ext;
   logic [jpd_pkg::NUM_BUTTON_SLOTS-1:0]   pressed;

   assign step_hit = (cfg.step_key_code != '0) &&
                     (item.key_code == cfg.step_key_code);

   assign delta_ext = {{(jpd_pkg::COUNT_BITS-jpd_pkg::CODE_BITS)
                          {item.wheel_delta[jpd_pkg::CODE_BITS-1]}},
                       item.wheel_delta};

   for (genvar i = 0; i < jpd_pkg::NUM_BUTTON_SLOTS; i++) begin : g_slot
      assign pressed[i] = cfg.slot_enable[i] &&
         (cfg.slot_codes[i*jpd_pkg::CODE_BITS +: jpd_pkg::CODE_BITS] == item.key_code);
   end

   always_comb begin
      state_next.step_index = step_hit ? state.step_index + 2'd1 : state.step_index;
      state_next.jog_total  = state.jog_total + delta_ext;
   end

   always_comb begin
      result.step_size         = jpd_pkg::step_lookup(state_next.step_index);
      result.jog_count         = state_next.jog_total;
      result.jog_count_negated = '0 - state_next.jog_total;
      result.axis_enables      = jpd_pkg::axis_lookup(item.axis_code);
      result.buttons_pressed   = pressed;
   end

endmodule
`default_nettype wire

// File: src/jog_pendant_report_decoder_core.sv
// Jog pendant report decoder.
// Each item on the req_ channel is one pendant report: the button code, the
// axis selector code and the signed wheel delta. Each report gives exactly one
// item on the rsp_ channel: the step size, the running jog count and its
// negation, a one-hot or zero axis enable and the vector of pressed button slots.
// A report is captured in an input register, decoded combinationally against
// the held step index and jog count, and loaded into the result register,
// which drives rsp_tvalid; the held step index and count update with it.
// One report is taken every cycle while the receiver keeps rsp_tready high; the
// update of the step index and the 32-bit count in the decoder sets that rate.
// The csr_ port writes the step button code, the four words of slot codes and
// the slot enables; the user writes it only while no report is in flight, and
// the block does not enforce that. Reset clears the configuration, the step
// index (step size one), the jog count and both pipeline stages.
// When the receiver holds rsp_tready low, the result stays in place, the input
// register fills, and then req_tready drops until the result is taken.
`default_nettype none
module jog_pendant_report_decoder_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // key_code [7:0], axis_code [15:8], wheel_delta [23:16]
   input  wire logic [jpd_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // step_size [9:0], jog_count [41:10], jog_count_negated [73:42],
   // axis_enables [80:74], buttons_pressed [112:81], zero [119:113]
   output      logic [jpd_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [jpd_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [jpd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   jpd_pkg::cfg_type    cfg;
   jpd_pkg::item_type   item_ff;
   jpd_pkg::state_type  state_ff;
   jpd_pkg::state_type  state_in;
   jpd_pkg::result_type result_ff;
   jpd_pkg::result_type result_in;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                rsp_load;
   logic                req_take;

   jpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jpd_decode u_decode (
      .cfg        (cfg),
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   assign rsp_load   = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || rsp_load;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_tdata;
      end
      if (rsp_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(jpd_pkg::RSP_DATA_BITS-jpd_pkg::RSP_USED_BITS){1'b0}}, result_ff};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result pending right after reset.");

   a_axis_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(result_ff.axis_enables))
      else $error("Axis enable is not one-hot.");

   a_step_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.step_size == jpd_pkg::STEP_1 ||
                        result_ff.step_size == jpd_pkg::STEP_10 ||
                        result_ff.step_size == jpd_pkg::STEP_100 ||
                        result_ff.step_size == jpd_pkg::STEP_1000))
      else $error("Illegal step size.");

   a_negation: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (result_ff.jog_count + result_ff.jog_count_negated == '0))
      else $error("Negated count does not match count.");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (result_ff.jog_count == state_ff.jog_total))
      else $error("Result count differs from held count.");

endmodule
`default_nettype wire

// File: dv/jog_pendant_report_decoder_core_tb.sv
`timescale 1ns / 1ps
module jog_pendant_report_decoder_core_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 240;
   localparam logic [jpd_pkg::CSR_ADDR_BITS-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [jpd_pkg::CSR_ADDR_BITS-1:0] REG_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [jpd_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [jpd_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [jpd_pkg::CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [jpd_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   jog_pendant_report_decoder_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Shadow copy of the configuration and the decoder state.
   logic [jpd_pkg::CODE_BITS-1:0] step_code = '0;
   logic [jpd_pkg::SLOT_CODE_BITS-1:0] code_map = '0;
   logic [jpd_pkg::NUM_BUTTON_SLOTS-1:0] slot_enable = '0;
   logic [1:0] step_sel = '0;
   logic [jpd_pkg::COUNT_BITS-1:0] jog_sum = '0;

   jpd_pkg::item_type report_queue[$];
   jpd_pkg::result_type decoded_queue[$];

   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   logic hold_go = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int errors = 0;
   int reports_accepted = 0;
   int results_checked = 0;
   int csr_writes = 0;

   function automatic jpd_pkg::result_type decode_report(input jpd_pkg::item_type rpt);
      jpd_pkg::result_type res;
      logic [jpd_pkg::NUM_BUTTON_SLOTS-1:0] pressed;
      pressed = '0;
      if (step_code != '0 && rpt.key_code == step_code) begin
         step_sel = step_sel + 2'd1;
      end
      jog_sum = jog_sum + {{(jpd_pkg::COUNT_BITS-jpd_pkg::CODE_BITS)
                            {rpt.wheel_delta[jpd_pkg::CODE_BITS-1]}},
                           rpt.wheel_delta};
      for (int s = 0; s < jpd_pkg::NUM_BUTTON_SLOTS; s++) begin
         if (slot_enable[s] &&
             code_map[s*jpd_pkg::CODE_BITS +: jpd_pkg::CODE_BITS] == rpt.key_code) begin
            pressed[s] = 1'b1;
         end
      end
      case (step_sel)
         2'd0: res.step_size = jpd_pkg::STEP_1;
         2'd1: res.step_size = jpd_pkg::STEP_10;
         2'd2: res.step_size = jpd_pkg::STEP_100;
         default: res.step_size = jpd_pkg::STEP_1000;
      endcase
      case (rpt.axis_code)
         jpd_pkg::AXIS_IDLE: res.axis_enables = 7'b000_0001;
         jpd_pkg::AXIS_X: res.axis_enables = 7'b000_0010;
         jpd_pkg::AXIS_Y: res.axis_enables = 7'b000_0100;
         jpd_pkg::AXIS_Z: res.axis_enables = 7'b000_1000;
         jpd_pkg::AXIS_A: res.axis_enables = 7'b001_0000;
         jpd_pkg::AXIS_RATE: res.axis_enables = 7'b010_0000;
         jpd_pkg::AXIS_SPIN: res.axis_enables = 7'b100_0000;
         default: res.axis_enables = '0;
      endcase
      res.jog_count = jog_sum;
      res.jog_count_negated = 32'd0 - jog_sum;
      res.buttons_pressed = pressed;
      return res;
   endfunction

   function automatic jpd_pkg::item_type make_report(input logic [7:0] button,
                                                     input logic [7:0] axis,
                                                     input logic [7:0] delta);
      jpd_pkg::item_type rpt;
      rpt.key_code = button;
      rpt.axis_code = axis;
      rpt.wheel_delta = delta;
      return rpt;
   endfunction

   // Mostly reports that hit a configured code and a valid axis, with some noise.
   function automatic jpd_pkg::item_type random_report();
      jpd_pkg::item_type rpt;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         rpt.key_code = code_map[$urandom_range(jpd_pkg::NUM_BUTTON_SLOTS-1)*jpd_pkg::CODE_BITS
                                 +: jpd_pkg::CODE_BITS];
      end else if (pick < 55) begin
         rpt.key_code = step_code;
      end else begin
         rpt.key_code = 8'($urandom);
      end
      if ($urandom_range(99) < 70) begin
         case ($urandom_range(6))
            0: rpt.axis_code = jpd_pkg::AXIS_IDLE;
            1: rpt.axis_code = jpd_pkg::AXIS_X;
            2: rpt.axis_code = jpd_pkg::AXIS_Y;
            3: rpt.axis_code = jpd_pkg::AXIS_Z;
            4: rpt.axis_code = jpd_pkg::AXIS_A;
            5: rpt.axis_code = jpd_pkg::AXIS_SPIN;
            default: rpt.axis_code = jpd_pkg::AXIS_RATE;
         endcase
      end else begin
         rpt.axis_code = 8'($urandom);
      end
      rpt.wheel_delta = 8'($urandom);
      return rpt;
   endfunction

   task automatic note_mismatch(input string what, input logic [127:0] want,
                                input logic [127:0] got);
      errors++;
      if (errors <= 10) begin
         $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
   endtask

   // Called at a clock edge; the write takes place at the next edge.
   task automatic write_csr(input logic [jpd_pkg::CSR_ADDR_BITS-1:0] idx,
                            input logic [jpd_pkg::CSR_DATA_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      csr_writes++;
      case (idx)
         jpd_pkg::REG_STEP_BUTTON: step_code = val[jpd_pkg::CODE_BITS-1:0];
         jpd_pkg::REG_CODES_WORD0:
            code_map[0*jpd_pkg::CODE_WORD_BITS +: jpd_pkg::CODE_WORD_BITS] = val;
         jpd_pkg::REG_CODES_WORD1:
            code_map[1*jpd_pkg::CODE_WORD_BITS +: jpd_pkg::CODE_WORD_BITS] = val;
         jpd_pkg::REG_CODES_WORD2:
            code_map[2*jpd_pkg::CODE_WORD_BITS +: jpd_pkg::CODE_WORD_BITS] = val;
         jpd_pkg::REG_CODES_WORD3:
            code_map[3*jpd_pkg::CODE_WORD_BITS +: jpd_pkg::CODE_WORD_BITS] = val;
         jpd_pkg::REG_SLOT_ENABLE: slot_enable = val[jpd_pkg::NUM_BUTTON_SLOTS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (report_queue.size() != 0 || req_tvalid || decoded_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      repeat (count) report_queue.push_back(random_report());
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         decoded_queue.push_back(decode_report(jpd_pkg::item_type'(req_tdata)));
         reports_accepted++;
      end
      if (!req_tvalid || req_tready) begin
         if (!reset && report_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= report_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_go) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : rsp_check
      jpd_pkg::result_type got;
      jpd_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = jpd_pkg::result_type'(rsp_tdata[jpd_pkg::RSP_USED_BITS-1:0]);
         if (decoded_queue.size() == 0) begin
            note_mismatch("unexpected item", '0, 128'(rsp_tdata));
         end else begin
            want = decoded_queue.pop_front();
            results_checked++;
            if (got.step_size !== want.step_size) begin
               note_mismatch("step_size", 128'(want.step_size), 128'(got.step_size));
            end
            if (got.jog_count !== want.jog_count) begin
               note_mismatch("jog_count", 128'(want.jog_count), 128'(got.jog_count));
            end
            if (got.jog_count_negated !== want.jog_count_negated) begin
               note_mismatch("jog_count_negated", 128'(want.jog_count_negated),
                             128'(got.jog_count_negated));
            end
            if (got.axis_enables !== want.axis_enables) begin
               note_mismatch("axis_enables", 128'(want.axis_enables),
                             128'(got.axis_enables));
            end
            if (got.buttons_pressed !== want.buttons_pressed) begin
               note_mismatch("buttons_pressed", 128'(want.buttons_pressed),
                             128'(got.buttons_pressed));
            end
            if (rsp_tdata[jpd_pkg::RSP_DATA_BITS-1:jpd_pkg::RSP_USED_BITS] !== '0) begin
               note_mismatch("padding", '0,
                             128'(rsp_tdata[jpd_pkg::RSP_DATA_BITS-1:jpd_pkg::RSP_USED_BITS]));
            end
         end
      end
      rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("jog_pendant_report_decoder_core_tb failed");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With stepping disabled, a zero button code must not advance the step.
      report_queue.push_back(make_report(8'h00, jpd_pkg::AXIS_IDLE, 8'h00));
      report_queue.push_back(make_report(8'hFF, jpd_pkg::AXIS_X, 8'h7F));
      report_queue.push_back(make_report(8'h00, 8'hFF, 8'h80));
      report_queue.push_back(make_report(8'h80, jpd_pkg::AXIS_Y, 8'hFF));
      wait_drained();

      write_csr(jpd_pkg::REG_STEP_BUTTON, 64'h0000_0000_0000_00A5);
      write_csr(jpd_pkg::REG_CODES_WORD0, 64'h3807_0605_0403_0200);
      write_csr(jpd_pkg::REG_CODES_WORD1, 64'hFFFF_1010_A5A5_8080);
      write_csr(jpd_pkg::REG_CODES_WORD2, 64'h55AA_55AA_0102_0304);
      write_csr(jpd_pkg::REG_CODES_WORD3, 64'h0102_0408_1020_4080);
      write_csr(jpd_pkg::REG_SLOT_ENABLE, 64'h0000_0000_5A5A_F00F);
      write_csr(REG_SPARE_6, '1);
      write_csr(REG_SPARE_7, '1);
      csr_we <= 1'b0;

      // Four presses of the step button wrap the step size back to one; a fifth selects ten.
      report_queue.push_back(make_report(8'hA5, jpd_pkg::AXIS_Z, 8'h80));
      report_queue.push_back(make_report(8'hA5, jpd_pkg::AXIS_A, 8'h80));
      report_queue.push_back(make_report(8'hA5, jpd_pkg::AXIS_SPIN, 8'h01));
      report_queue.push_back(make_report(8'hA5, jpd_pkg::AXIS_RATE, 8'h7F));
      report_queue.push_back(make_report(8'hA5, jpd_pkg::AXIS_IDLE, 8'hFF));
      report_queue.push_back(make_report(8'h00, jpd_pkg::AXIS_X, 8'h01));
      report_queue.push_back(make_report(8'hFF, 8'h16, 8'h7F));
      report_queue.push_back(make_report(8'h10, 8'h10, 8'h7F));
      report_queue.push_back(make_report(8'h80, jpd_pkg::AXIS_Y, 8'h80));
      report_queue.push_back(make_report(8'h01, 8'h19, 8'h80));
      report_queue.push_back(make_report(8'h55, jpd_pkg::AXIS_Z, 8'h00));
      report_queue.push_back(make_report(8'h38, 8'h7F, 8'h80));
      report_queue.push_back(make_report(8'h7F, jpd_pkg::AXIS_A, 8'h40));
      report_queue.push_back(make_report(8'h02, 8'h80, 8'hC0));
      wait_drained();

      write_csr(jpd_pkg::REG_STEP_BUTTON, 64'(8'($urandom_range(255, 1))));
      write_csr(jpd_pkg::REG_CODES_WORD0, {$urandom, $urandom});
      write_csr(jpd_pkg::REG_CODES_WORD1, {$urandom, $urandom});
      write_csr(jpd_pkg::REG_CODES_WORD2, {$urandom, $urandom});
      write_csr(jpd_pkg::REG_CODES_WORD3, {$urandom, $urandom});
      write_csr(jpd_pkg::REG_SLOT_ENABLE, 64'($urandom));
      csr_we <= 1'b0;
      send_gap_pct <= 35;
      recv_gap_pct <= 85;
      queue_random(280);
      wait_drained();

      // Every slot enabled with the same code as the step button.
      write_csr(jpd_pkg::REG_STEP_BUTTON, 64'h0000_0000_0000_00FF);
      write_csr(jpd_pkg::REG_CODES_WORD0, '1);
      write_csr(jpd_pkg::REG_CODES_WORD1, '1);
      write_csr(jpd_pkg::REG_CODES_WORD2, '1);
      write_csr(jpd_pkg::REG_CODES_WORD3, '1);
      write_csr(jpd_pkg::REG_SLOT_ENABLE, 64'hFFFF_FFFF);
      csr_we <= 1'b0;
      send_gap_pct <= 85;
      recv_gap_pct <= 35;
      queue_random(280);
      wait_drained();

      write_csr(jpd_pkg::REG_STEP_BUTTON, '0);
      write_csr(jpd_pkg::REG_CODES_WORD0, {$urandom, $urandom});
      write_csr(jpd_pkg::REG_CODES_WORD1, {$urandom, $urandom});
      write_csr(jpd_pkg::REG_CODES_WORD2, {$urandom, $urandom});
      write_csr(jpd_pkg::REG_CODES_WORD3, {$urandom, $urandom});
      write_csr(jpd_pkg::REG_SLOT_ENABLE, 64'($urandom));
      csr_we <= 1'b0;
      send_gap_pct <= 0;
      recv_gap_pct <= 0;
      // The receiver holds off while the sender keeps offering, so the block backs up.
      queue_random(60);
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      wait_drained();

      write_csr(jpd_pkg::REG_STEP_BUTTON, 64'(8'($urandom_range(255, 1))));
      csr_we <= 1'b0;
      queue_random(220);
      wait_drained();

      errors += decoded_queue.size();
      $display("%0d reports decoded and %0d results checked across %0d register writes,",
               reports_accepted, results_checked, csr_writes);
      $display("with stalls on both sides, a long output hold-off and %0d errors.", errors);
      if (errors == 0) begin
         $display("jog_pendant_report_decoder_core_tb passed");
      end else begin
         $display("jog_pendant_report_decoder_core_tb failed");
      end
      $finish;
   end

endmodule
